/* hw/rtl/pwc_pkg.sv */
// pwc_pkg: shared types and constants of the pump watering controller
// event kinds, led codes, register map, config and result structs
// no dependencies
package pwc_pkg;

  localparam int unsigned MoistW    = 10;
  localparam int unsigned RunW      = 16;
  localparam int unsigned IntervalW = 8;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;

  localparam logic [MoistW-1:0]    MoistMax         = 10'd1000;
  localparam logic [MoistW-1:0]    HeldReset        = 10'd240;
  localparam logic [MoistW-1:0]    LowMoistReset    = 10'd300;
  localparam logic [MoistW-1:0]    HighMoistReset   = 10'd700;
  localparam logic [RunW-1:0]      AutoLimitReset   = 16'd30;
  localparam logic [RunW-1:0]      ManualRunReset   = 16'd10;
  localparam logic [IntervalW-1:0] IntervalReset    = 8'd5;
  localparam logic [RunW-1:0]      RunMax           = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_TOGGLE = 2'd1,
    KIND_MANUAL = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    LED_OK      = 2'd0,
    LED_PUMPING = 2'd1,
    LED_DRY     = 2'd2,
    LED_FAULT   = 2'd3
  } led_e;

  typedef enum logic [2:0] {
    REG_LOW_MOIST  = 3'd0,
    REG_HIGH_MOIST = 3'd1,
    REG_AUTO_LIMIT = 3'd2,
    REG_MANUAL_RUN = 3'd3,
    REG_INTERVAL   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [MoistW-1:0]    low_moisture;
    logic [MoistW-1:0]    high_moisture;
    logic [RunW-1:0]      auto_limit_seconds;
    logic [RunW-1:0]      manual_run_seconds;
    logic [IntervalW-1:0] sample_interval;
  } cfg_t;

  typedef struct packed {
    logic              pump_on;
    led_e              led_code;
    logic              manual_mode;
    logic              sample_latched;
    logic [MoistW-1:0] moisture_held;
  } res_t;

endpackage

/* hw/rtl/pwc_cfg_regs.sv */
// pwc_cfg_regs: apb-style configuration register file
// depends on pwc_pkg
module pwc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pwc_pkg::AddrW-1:0]  paddr,
  input  logic [pwc_pkg::DataW-1:0]  pwdata,
  output logic [pwc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output pwc_pkg::cfg_t              cfg_o
);

  pwc_pkg::cfg_t     cfg_q, cfg_d;
  logic              wr_en;
  pwc_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = pwc_pkg::reg_idx_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        pwc_pkg::REG_LOW_MOIST:  cfg_d.low_moisture       = pwdata[pwc_pkg::MoistW-1:0];
        pwc_pkg::REG_HIGH_MOIST: cfg_d.high_moisture      = pwdata[pwc_pkg::MoistW-1:0];
        pwc_pkg::REG_AUTO_LIMIT: cfg_d.auto_limit_seconds = pwdata[pwc_pkg::RunW-1:0];
        pwc_pkg::REG_MANUAL_RUN: cfg_d.manual_run_seconds = pwdata[pwc_pkg::RunW-1:0];
        pwc_pkg::REG_INTERVAL:   cfg_d.sample_interval    = pwdata[pwc_pkg::IntervalW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pwc_pkg::REG_LOW_MOIST:  prdata = {22'd0, cfg_q.low_moisture};
      pwc_pkg::REG_HIGH_MOIST: prdata = {22'd0, cfg_q.high_moisture};
      pwc_pkg::REG_AUTO_LIMIT: prdata = {16'd0, cfg_q.auto_limit_seconds};
      pwc_pkg::REG_MANUAL_RUN: prdata = {16'd0, cfg_q.manual_run_seconds};
      pwc_pkg::REG_INTERVAL:   prdata = {24'd0, cfg_q.sample_interval};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_moisture       <= pwc_pkg::LowMoistReset;
      cfg_q.high_moisture      <= pwc_pkg::HighMoistReset;
      cfg_q.auto_limit_seconds <= pwc_pkg::AutoLimitReset;
      cfg_q.manual_run_seconds <= pwc_pkg::ManualRunReset;
      cfg_q.sample_interval    <= pwc_pkg::IntervalReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/pwc_state.sv */
// pwc_state: controller state registers and per-event update logic
// depends on pwc_pkg
module pwc_state (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_en_i,
  input  pwc_pkg::kind_e              kind_i,
  input  logic [pwc_pkg::MoistW-1:0]  sample_i,
  input  pwc_pkg::cfg_t               cfg_i,
  output pwc_pkg::res_t               res_o
);

  logic                           mode_q, mode_d;
  logic                           pump_q, pump_d;
  pwc_pkg::led_e                  led_q, led_d;
  logic [pwc_pkg::RunW-1:0]       run_q, run_d;
  logic [pwc_pkg::IntervalW-1:0]  stick_q, stick_d;
  logic [pwc_pkg::MoistW-1:0]     held_q, held_d;
  logic                           latched;
  logic [pwc_pkg::IntervalW:0]    stick_nxt;

  assign stick_nxt = {1'b0, stick_q} + {{pwc_pkg::IntervalW{1'b0}}, 1'b1};

  always_comb begin
    mode_d  = mode_q;
    pump_d  = pump_q;
    led_d   = led_q;
    run_d   = run_q;
    stick_d = stick_q;
    held_d  = held_q;
    latched = 1'b0;
    case (kind_i)
      pwc_pkg::KIND_TICK: begin
        if (stick_nxt >= {1'b0, cfg_i.sample_interval}) begin
          stick_d = '0;
          held_d  = (sample_i > pwc_pkg::MoistMax) ? pwc_pkg::MoistMax : sample_i;
          latched = 1'b1;
        end else begin
          stick_d = stick_nxt[pwc_pkg::IntervalW-1:0];
        end
        if (!mode_q) begin
          if ((held_d < cfg_i.low_moisture) && !pump_d) begin
            pump_d = 1'b1;
            led_d  = pwc_pkg::LED_PUMPING;
            run_d  = '0;
          end
          if (pump_d) begin
            if (run_d != pwc_pkg::RunMax) run_d = run_d + 1'b1;
            if ((held_d > cfg_i.high_moisture) || (run_d >= cfg_i.auto_limit_seconds)) begin
              pump_d = 1'b0;
              led_d  = (held_d < cfg_i.low_moisture) ? pwc_pkg::LED_DRY : pwc_pkg::LED_OK;
            end
          end
        end else if (pump_d) begin
          if (run_d != pwc_pkg::RunMax) run_d = run_d + 1'b1;
          if (run_d >= cfg_i.manual_run_seconds) begin
            pump_d = 1'b0;
            led_d  = pwc_pkg::LED_OK;
          end
        end
      end
      pwc_pkg::KIND_TOGGLE: begin
        mode_d = !mode_q;
        if (mode_d) pump_d = 1'b0;
      end
      pwc_pkg::KIND_MANUAL: begin
        if (mode_q && !pump_q) begin
          pump_d = 1'b1;
          led_d  = pwc_pkg::LED_PUMPING;
          run_d  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      pump_q  <= 1'b0;
      led_q   <= pwc_pkg::LED_OK;
      run_q   <= '0;
      stick_q <= '0;
      held_q  <= pwc_pkg::HeldReset;
    end else if (step_en_i) begin
      mode_q  <= mode_d;
      pump_q  <= pump_d;
      led_q   <= led_d;
      run_q   <= run_d;
      stick_q <= stick_d;
      held_q  <= held_d;
    end
  end

  assign res_o.pump_on        = pump_d;
  assign res_o.led_code       = led_d;
  assign res_o.manual_mode    = mode_d;
  assign res_o.sample_latched = latched;
  assign res_o.moisture_held  = held_d;

`ifndef NO_ASSERTIONS
  a_pump_led : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pump_q |-> (led_q == pwc_pkg::LED_PUMPING))
    else $error("pump running without watering led");
  a_held_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= pwc_pkg::MoistMax)
    else $error("held moisture out of range");
  a_hold_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> ($stable(mode_q) && $stable(pump_q) && $stable(run_q)))
    else $error("state changed without an event");
`endif

endmodule

/* hw/rtl/pump_watering_controller.sv */
// pump_watering_controller: pump and status led controller, top level
// path: the input register holds the event, the state update result is registered in the output register
// throughput: one event per cycle; stall on the output stalls the input register
// reset: rst_ni asynchronous active low; clears config and state registers to their defaults
// and the held moisture to 240, pipeline empty
// depends on pwc_pkg, pwc_cfg_regs, pwc_state
module pump_watering_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [pwc_pkg::MoistW-1:0]  moisture_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        pump_on_o,
  output logic [1:0]                  led_code_o,
  output logic                        manual_mode_o,
  output logic                        sample_latched_o,
  output logic [pwc_pkg::MoistW-1:0]  moisture_held_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pwc_pkg::AddrW-1:0]   paddr,
  input  logic [pwc_pkg::DataW-1:0]   pwdata,
  output logic [pwc_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  pwc_pkg::cfg_t               cfg;
  pwc_pkg::res_t               res;
  logic                        in_valid_q, in_valid_d;
  logic [1:0]                  kind_q;
  logic [pwc_pkg::MoistW-1:0]  sample_q;
  logic                        out_valid_q, out_valid_d;
  pwc_pkg::res_t               out_q;
  logic                        in_take;
  logic                        advance;

  pwc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwc_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .kind_i    (pwc_pkg::kind_e'(kind_q)),
    .sample_i  (sample_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q   <= kind_i;
      sample_q <= moisture_sample_i;
    end
    if (advance) out_q <= res;
  end

  assign out_valid_o      = out_valid_q;
  assign pump_on_o        = out_q.pump_on;
  assign led_code_o       = out_q.led_code;
  assign manual_mode_o    = out_q.manual_mode;
  assign sample_latched_o = out_q.sample_latched;
  assign moisture_held_o  = out_q.moisture_held;

`ifndef NO_ASSERTIONS
  a_advance_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed event did not reach the output register");
  a_no_fault_led : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.led_code != pwc_pkg::LED_FAULT))
    else $error("fault led code produced");
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("stalled input item lost");
`endif

endmodule

/* bench/pump_watering_controller_test.sv */
`timescale 1ns / 1ps
// pump_watering_controller_test: self-checking bench for the pump watering controller
// directed and random events against an in-bench status predictor, apb register writes
// depends on pwc_pkg and pump_watering_controller
module pump_watering_controller_test;
  import pwc_pkg::*;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              in_valid_i        = 1'b0;
  logic              in_stall_o;
  logic [1:0]        kind_i            = KIND_TICK;
  logic [MoistW-1:0] moisture_sample_i = '0;
  logic              out_valid_o;
  logic              out_stall_i       = 1'b0;
  logic              pump_on_o;
  logic [1:0]        led_code_o;
  logic              manual_mode_o;
  logic              sample_latched_o;
  logic [MoistW-1:0] moisture_held_o;
  logic              psel              = 1'b0;
  logic              penable           = 1'b0;
  logic              pwrite            = 1'b0;
  logic [AddrW-1:0]  paddr             = '0;
  logic [DataW-1:0]  pwdata            = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // predicted controller state
  cfg_t                 ctrl_regs;
  logic                 manual_on;
  logic                 pump_running;
  led_e                 led_shown;
  logic [RunW-1:0]      run_count;
  logic [IntervalW-1:0] tick_count;
  logic [MoistW-1:0]    held_moisture;

  res_t pending_status[$];
  int   mismatch_count = 0;
  bit   no_gaps        = 1'b0;

  pump_watering_controller i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .moisture_sample_i(moisture_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pump_on_o        (pump_on_o),
    .led_code_o       (led_code_o),
    .manual_mode_o    (manual_mode_o),
    .sample_latched_o (sample_latched_o),
    .moisture_held_o  (moisture_held_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic res_t predict_status(kind_e event_kind, logic [MoistW-1:0] sample);
    res_t status;
    logic latched;
    latched = 1'b0;
    case (event_kind)
      KIND_TICK: begin
        if (int'(tick_count) + 1 >= int'(ctrl_regs.sample_interval)) begin
          tick_count    = '0;
          held_moisture = (sample > MoistMax) ? MoistMax : sample;
          latched       = 1'b1;
        end else begin
          tick_count = tick_count + 1'b1;
        end
        if (!manual_on) begin
          if (held_moisture < ctrl_regs.low_moisture && !pump_running) begin
            pump_running = 1'b1;
            led_shown    = LED_PUMPING;
            run_count    = '0;
          end
          if (pump_running) begin
            if (run_count != RunMax) run_count = run_count + 1'b1;
            if (held_moisture > ctrl_regs.high_moisture ||
                run_count >= ctrl_regs.auto_limit_seconds) begin
              pump_running = 1'b0;
              led_shown    = (held_moisture < ctrl_regs.low_moisture) ? LED_DRY : LED_OK;
            end
          end
        end else if (pump_running) begin
          if (run_count != RunMax) run_count = run_count + 1'b1;
          if (run_count >= ctrl_regs.manual_run_seconds) begin
            pump_running = 1'b0;
            led_shown    = LED_OK;
          end
        end
      end
      KIND_TOGGLE: begin
        manual_on = !manual_on;
        if (manual_on) pump_running = 1'b0;
      end
      KIND_MANUAL: begin
        if (manual_on && !pump_running) begin
          pump_running = 1'b1;
          led_shown    = LED_PUMPING;
          run_count    = '0;
        end
      end
      default: ;
    endcase
    status.pump_on        = pump_running;
    status.led_code       = led_shown;
    status.manual_mode    = manual_on;
    status.sample_latched = latched;
    status.moisture_held  = held_moisture;
    return status;
  endfunction

  task automatic report_field(string field, logic [15:0] want, logic [15:0] got);
    $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  // result side: random stall, compare each transfer with the oldest prediction
  always @(negedge clk_i) begin
    out_stall_i <= !no_gaps && ($urandom_range(99) < 36);
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got pump %0b led %0d",
                 $time, pump_on_o, led_code_o);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        if (pump_on_o !== want.pump_on)
          report_field("pump_on", 16'(want.pump_on), 16'(pump_on_o));
        if (led_code_o !== want.led_code)
          report_field("led_code", 16'(want.led_code), 16'(led_code_o));
        if (manual_mode_o !== want.manual_mode)
          report_field("manual_mode", 16'(want.manual_mode), 16'(manual_mode_o));
        if (sample_latched_o !== want.sample_latched)
          report_field("sample_latched", 16'(want.sample_latched), 16'(sample_latched_o));
        if (moisture_held_o !== want.moisture_held)
          report_field("moisture_held", 16'(want.moisture_held), 16'(moisture_held_o));
      end
    end
  end

  task automatic send_event(kind_e event_kind, logic [MoistW-1:0] sample);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= event_kind;
    moisture_sample_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
    pending_status.push_back(predict_status(event_kind, sample));
  endtask

  // drain the pipeline before touching registers or finishing
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] value);
    logic [DataW-1:0] kept;
    logic [DataW-1:0] readback;
    case (idx)
      REG_LOW_MOIST: begin
        ctrl_regs.low_moisture = value[MoistW-1:0];
        kept = DataW'(ctrl_regs.low_moisture);
      end
      REG_HIGH_MOIST: begin
        ctrl_regs.high_moisture = value[MoistW-1:0];
        kept = DataW'(ctrl_regs.high_moisture);
      end
      REG_AUTO_LIMIT: begin
        ctrl_regs.auto_limit_seconds = value[RunW-1:0];
        kept = DataW'(ctrl_regs.auto_limit_seconds);
      end
      REG_MANUAL_RUN: begin
        ctrl_regs.manual_run_seconds = value[RunW-1:0];
        kept = DataW'(ctrl_regs.manual_run_seconds);
      end
      default: begin
        ctrl_regs.sample_interval = value[IntervalW-1:0];
        kept = DataW'(ctrl_regs.sample_interval);
      end
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== kept) begin
      $display("%0t ns: register %s expected %0d, got %0d", $time, idx.name(), kept, readback);
      mismatch_count++;
    end
  endtask

  function automatic logic [MoistW-1:0] pick_moisture();
    int level;
    case ($urandom_range(2))
      0:       level = $urandom_range(1023);
      1:       level = int'(ctrl_regs.low_moisture) + $urandom_range(40) - 20;
      default: level = int'(ctrl_regs.high_moisture) + $urandom_range(40) - 20;
    endcase
    if (level < 0) level = 0;
    if (level > 1023) level = 1023;
    return MoistW'(level);
  endfunction

  // reset values, keys in both modes, toggles with the pump running
  task automatic test_defaults();
    send_event(KIND_UNUSED, 10'd1023);
    send_event(KIND_MANUAL, 10'd0);
    repeat (5) send_event(KIND_TICK, 10'd1023);
    send_event(KIND_TOGGLE, 10'd0);
    send_event(KIND_MANUAL, 10'd0);
    send_event(KIND_MANUAL, 10'd0);
    send_event(KIND_TICK, 10'd0);
    send_event(KIND_TOGGLE, 10'd0);
    repeat (4) send_event(KIND_TICK, 10'd0);
    send_event(KIND_TOGGLE, 10'd0);
  endtask

  // zero limits and interval, low threshold at its top
  task automatic test_zero_settings();
    settle();
    write_reg(REG_LOW_MOIST, 32'd1000);
    write_reg(REG_HIGH_MOIST, 32'd0);
    write_reg(REG_AUTO_LIMIT, 32'd0);
    write_reg(REG_MANUAL_RUN, 32'd0);
    write_reg(REG_INTERVAL, 32'd0);
    send_event(KIND_MANUAL, 10'd0);
    send_event(KIND_TICK, 10'd500);
    send_event(KIND_TOGGLE, 10'd0);
    send_event(KIND_TICK, 10'd0);
    send_event(KIND_TICK, 10'd1023);
  endtask

  // largest limits and interval, then the interval lowered below the running count
  task automatic test_interval_lowered();
    settle();
    write_reg(REG_LOW_MOIST, 32'd0);
    write_reg(REG_HIGH_MOIST, 32'd1000);
    write_reg(REG_AUTO_LIMIT, 32'd65535);
    write_reg(REG_MANUAL_RUN, 32'd65535);
    write_reg(REG_INTERVAL, 32'd255);
    send_event(KIND_TICK, 10'd512);
    send_event(KIND_TICK, 10'd511);
    send_event(KIND_TICK, 10'd682);
    settle();
    write_reg(REG_INTERVAL, 32'd2);
    send_event(KIND_TICK, 10'd341);
  endtask

  task automatic test_random(int count, bit steady);
    int   pick;
    kind_e event_kind;
    settle();
    write_reg(REG_LOW_MOIST, $urandom_range(1000));
    if ($urandom_range(1)) write_reg(REG_HIGH_MOIST, $urandom_range(1000, ctrl_regs.low_moisture));
    else write_reg(REG_HIGH_MOIST, $urandom_range(1000));
    write_reg(REG_AUTO_LIMIT, ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40));
    write_reg(REG_MANUAL_RUN, ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40));
    write_reg(REG_INTERVAL, ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(8));
    no_gaps = steady;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 78)      event_kind = KIND_TICK;
      else if (pick < 88) event_kind = KIND_TOGGLE;
      else if (pick < 96) event_kind = KIND_MANUAL;
      else                event_kind = KIND_UNUSED;
      send_event(event_kind, pick_moisture());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    ctrl_regs.low_moisture       = LowMoistReset;
    ctrl_regs.high_moisture      = HighMoistReset;
    ctrl_regs.auto_limit_seconds = AutoLimitReset;
    ctrl_regs.manual_run_seconds = ManualRunReset;
    ctrl_regs.sample_interval    = IntervalReset;
    manual_on     = 1'b0;
    pump_running  = 1'b0;
    led_shown     = LED_OK;
    run_count     = '0;
    tick_count    = '0;
    held_moisture = HeldReset;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_defaults();
    test_zero_settings();
    test_interval_lowered();
    test_random(180, 1'b0);
    test_random(150, 1'b1);
    test_random(120, 1'b0);
    test_random(100, 1'b0);
    settle();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/pwc_pkg.sv
hw/rtl/pwc_cfg_regs.sv
hw/rtl/pwc_state.sv
hw/rtl/pump_watering_controller.sv
bench/pump_watering_controller_test.sv
